>>> rtl/core/pid_controller_antiwindup_macros.svh
// ---------------------------------------------------------------------------
// PID controller assertion macros
// Shared assertion forms for the port checker; the checker supplies clk.
// ---------------------------------------------------------------------------
`ifndef PID_CONTROLLER_ANTIWINDUP_MACROS_SVH
`define PID_CONTROLLER_ANTIWINDUP_MACROS_SVH

// antecedent, then consequent in the cycle after
`define PIDAW_ASSERT_NEXT(lbl, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("pid_controller_antiwindup: assertion failed");

// antecedent and consequent in the same cycle
`define PIDAW_ASSERT_SAME(lbl, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("pid_controller_antiwindup: assertion failed");

`endif

>>> rtl/core/pidaw_pkg.sv
// ---------------------------------------------------------------------------
// PID controller package
// Widths, digit size and configuration register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package pidaw_pkg;

  localparam int DataWidth    = 16;
  localparam int IntegWidth   = 40;
  localparam int SumWidth     = 56;  // holds any P+I+D sum exactly
  localparam int DigitBits    = 4;
  localparam int GainFracBits = 12;
  localparam int CfgIdxWidth  = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_OUT_MAX = 3'd0,
    CFG_OUT_MIN = 3'd1,
    CFG_GAIN_P  = 3'd2,
    CFG_GAIN_I  = 3'd3,
    CFG_GAIN_D  = 3'd4
  } cfg_index_t;

endpackage

`default_nettype wire

>>> rtl/core/pid_controller_antiwindup.sv
// ---------------------------------------------------------------------------
// PID controller with clamping anti-windup
// Digit-serial P+I+D: one shared 17x4 multiply-add unit, radix-16 passes.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats (target, measured, elapsed_ticks) are taken on in_valid with
//   in_stall low. in_stall is high from the accepted beat until its result
//   has been loaded into the output register.
//   Work per beat: an integral update (skipped while the previous output was
//   clamped), then three passes for P, I and D through the shared
//   multiply-add unit, 4 bits of the multiplier per cycle, and a final shift
//   and clamp step. The result is registered at the end of that step; the
//   next beat can be taken in the cycle after that. The derivative divider
//   runs bit-serially, in parallel with the integral, P and I passes.
//   The output register holds a finished beat; while out_stall is high it
//   holds still, the block already accepts the next input, and the final
//   clamp stage waits for the register to free up.
//   Configuration writes (cfg_valid/cfg_ready) are taken at any time but are
//   meant for idle periods. Reset (rst, synchronous) clears the integral, the
//   previous measurement and the windup hold, and loads the register defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_controller_antiwindup
  import pidaw_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DataWidth-1:0]  target,
  input  logic signed [DataWidth-1:0]  measured,
  input  logic        [DataWidth-1:0]  elapsed_ticks,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DataWidth-1:0]  drive,
  output logic                         clamped,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [CfgIdxWidth-1:0] cfg_index,
  input  logic        [DataWidth-1:0]  cfg_data
);

  localparam int ErrWidth   = DataWidth + 1;
  localparam int ProdWidth  = ErrWidth + DigitBits + 1;
  localparam int TWidth     = ProdWidth + 1;
  localparam int HWidth     = TWidth - DigitBits;
  localparam int IntSteps   = IntegWidth / DigitBits;
  localparam int SumSteps   = SumWidth / DigitBits;
  localparam int StepWidth  = $clog2(SumSteps);
  localparam int DivCntW    = $clog2(DataWidth + 1);

  localparam logic [IntegWidth-1:0] IntegMax = {1'b0, {(IntegWidth-1){1'b1}}};
  localparam logic [IntegWidth-1:0] IntegMin = {1'b1, {(IntegWidth-1){1'b0}}};

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_INT  = 6'b000010,
    ST_PP   = 6'b000100,
    ST_PI   = 6'b001000,
    ST_PD   = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state;

  logic signed [DataWidth-1:0]  out_max, out_min, gain_p, gain_i, gain_d;
  logic        [IntegWidth-1:0] integ;
  logic signed [DataWidth-1:0]  prev_meas;
  logic                         hold;

  logic signed [ErrWidth-1:0]   err;
  logic        [DataWidth-1:0]  ticks;
  logic signed [ErrWidth-1:0]   mcand;
  logic        [IntegWidth-1:0] mplier;
  logic signed [HWidth-1:0]     carry;
  logic        [SumWidth-1:0]   sum;
  logic        [StepWidth-1:0]  step;

  logic        [DataWidth-1:0]  div_rem, div_quo;
  logic                         div_neg;
  logic        [DivCntW-1:0]    div_cnt;

  // capture arithmetic
  logic signed [ErrWidth-1:0]   cap_err, cap_diff, cap_diff_neg;
  logic        [DataWidth-1:0]  cap_mag;

  always_comb begin
    cap_err      = {target[DataWidth-1], target} - {measured[DataWidth-1], measured};
    cap_diff     = {measured[DataWidth-1], measured} - {prev_meas[DataWidth-1], prev_meas};
    cap_diff_neg = -cap_diff;
    cap_mag      = cap_diff[ErrWidth-1] ? cap_diff_neg[DataWidth-1:0]
                                        : cap_diff[DataWidth-1:0];
  end

  // shared multiply-add digit step
  logic        [DigitBits-1:0]  digit, acc_digit;
  logic signed [ProdWidth-1:0]  pprod;
  logic        [TWidth-1:0]     t;
  logic signed [HWidth-1:0]     carry_next;
  logic        [IntegWidth-1:0] mplier_shift, integ_rot;
  logic                         in_pass, last_step, integ_ovf, acc_sign;

  always_comb begin
    in_pass      = (state == ST_INT) || (state == ST_PP) || (state == ST_PI)
                || (state == ST_PD);
    last_step    = (state == ST_INT) ? (step == StepWidth'(IntSteps - 1))
                                     : (step == StepWidth'(SumSteps - 1));
    digit     = mplier[DigitBits-1:0];
    acc_digit = (state == ST_INT) ? integ[DigitBits-1:0] : sum[DigitBits-1:0];
    // top digit of the integral carries its sign
    acc_sign  = (state == ST_INT) && last_step && integ[DigitBits-1];
    pprod     = ProdWidth'(mcand) * ProdWidth'($signed({1'b0, digit}));
    t         = {{(TWidth-HWidth){carry[HWidth-1]}}, carry}
              + {{(TWidth-ProdWidth){pprod[ProdWidth-1]}}, pprod}
              + {{(TWidth-DigitBits){acc_sign}}, acc_digit};
    carry_next   = t[TWidth-1:DigitBits];
    mplier_shift = {{DigitBits{mplier[IntegWidth-1]}}, mplier[IntegWidth-1:DigitBits]};
    integ_rot    = {t[DigitBits-1:0], integ[IntegWidth-1:DigitBits]};
    integ_ovf    = (carry_next != {HWidth{integ_rot[IntegWidth-1]}});
  end

  // divider step and derivative
  logic [DataWidth:0]           div_trial;
  logic [DataWidth:0]           div_sub;
  logic signed [ErrWidth-1:0]   deriv, quo_ext;

  always_comb begin
    div_trial = {div_rem, div_quo[DataWidth-1]};
    div_sub   = div_trial - {1'b0, ticks};
    quo_ext   = {1'b0, div_quo};
    if (ticks == '0) begin
      deriv = '0;
    end else if (div_neg) begin
      deriv = -quo_ext;
    end else begin
      deriv = quo_ext;
    end
  end

  // floor shift and clamp
  logic signed [SumWidth-1:0]  y, max_ext, min_ext;
  logic signed [DataWidth-1:0] y_clamped;
  logic                        clip;

  always_comb begin
    y       = $signed(sum) >>> GainFracBits;
    max_ext = {{(SumWidth-DataWidth){out_max[DataWidth-1]}}, out_max};
    min_ext = {{(SumWidth-DataWidth){out_min[DataWidth-1]}}, out_min};
    if (y > max_ext) begin
      y_clamped = out_max;
      clip      = 1'b1;
    end else if (y < min_ext) begin
      y_clamped = out_min;
      clip      = 1'b1;
    end else begin
      y_clamped = y[DataWidth-1:0];
      clip      = 1'b0;
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      hold      <= 1'b0;
      integ     <= '0;
      prev_meas <= '0;
      div_cnt   <= '0;
      out_max   <= {1'b0, {(DataWidth-1){1'b1}}};
      out_min   <= {1'b1, {(DataWidth-1){1'b0}}};
      gain_p    <= '0;
      gain_i    <= '0;
      gain_d    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OUT_MAX: out_max <= cfg_data;
          CFG_OUT_MIN: out_min <= cfg_data;
          CFG_GAIN_P:  gain_p  <= cfg_data;
          CFG_GAIN_I:  gain_i  <= cfg_data;
          CFG_GAIN_D:  gain_d  <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end

      // restoring divide of |diff| by ticks, MSB first
      if (div_cnt != '0) begin
        div_cnt <= div_cnt - 1'b1;
        if (!div_sub[DataWidth]) begin
          div_rem <= div_sub[DataWidth-1:0];
          div_quo <= {div_quo[DataWidth-2:0], 1'b1};
        end else begin
          div_rem <= div_trial[DataWidth-1:0];
          div_quo <= {div_quo[DataWidth-2:0], 1'b0};
        end
      end

      if (in_pass && !last_step) begin
        mplier <= mplier_shift;
        carry  <= carry_next;
        step   <= step + 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            err       <= cap_err;
            ticks     <= elapsed_ticks;
            prev_meas <= measured;
            div_rem   <= '0;
            div_quo   <= cap_mag;
            div_neg   <= cap_diff[ErrWidth-1];
            div_cnt   <= DivCntW'(DataWidth);
            sum       <= '0;
            carry     <= '0;
            step      <= '0;
            if (hold) begin
              state  <= ST_PP;
              mcand  <= {gain_p[DataWidth-1], gain_p};
              mplier <= {{(IntegWidth-ErrWidth){cap_err[ErrWidth-1]}}, cap_err};
            end else begin
              state  <= ST_INT;
              mcand  <= cap_err;
              mplier <= {{(IntegWidth-DataWidth){1'b0}}, elapsed_ticks};
            end
          end
        end
        ST_INT: begin
          if (last_step) begin
            // saturate when the carry-out does not match the new sign
            if (integ_ovf) begin
              integ <= carry_next[HWidth-1] ? IntegMin : IntegMax;
            end else begin
              integ <= integ_rot;
            end
            state  <= ST_PP;
            mcand  <= {gain_p[DataWidth-1], gain_p};
            mplier <= {{(IntegWidth-ErrWidth){err[ErrWidth-1]}}, err};
            carry  <= '0;
            step   <= '0;
          end else begin
            integ <= integ_rot;
          end
        end
        ST_PP: begin
          sum <= {t[DigitBits-1:0], sum[SumWidth-1:DigitBits]};
          if (last_step) begin
            state  <= ST_PI;
            mcand  <= {gain_i[DataWidth-1], gain_i};
            mplier <= integ;
            carry  <= '0;
            step   <= '0;
          end
        end
        ST_PI: begin
          sum <= {t[DigitBits-1:0], sum[SumWidth-1:DigitBits]};
          if (last_step) begin
            state  <= ST_PD;
            mcand  <= {gain_d[DataWidth-1], gain_d};
            mplier <= {{(IntegWidth-ErrWidth){deriv[ErrWidth-1]}}, deriv};
            carry  <= '0;
            step   <= '0;
          end
        end
        ST_PD: begin
          sum <= {t[DigitBits-1:0], sum[SumWidth-1:DigitBits]};
          if (last_step) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid || !out_stall) begin
            drive     <= y_clamped;
            clamped   <= clip;
            out_valid <= 1'b1;
            hold      <= clip;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pidaw_checker.sv
// ---------------------------------------------------------------------------
// PID controller port checker
// Watches the input and output channels over time; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "pid_controller_antiwindup_macros.svh"

module pidaw_checker
  import pidaw_pkg::*;
(
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic signed [DataWidth-1:0] drive,
  input logic                        clamped
);

  // an accepted beat keeps the input side busy afterwards
  `PIDAW_ASSERT_NEXT(a_busy_after_beat, rst, in_valid && !in_stall, in_stall ##1 in_stall)

  // a stalled result holds
  `PIDAW_ASSERT_NEXT(a_out_hold, rst, out_valid && out_stall, out_valid && $stable(drive) && $stable(clamped))

  // reset leaves both channels idle
  `PIDAW_ASSERT_NEXT(a_reset_idle, 1'b0, rst, !out_valid && !in_stall)

  // a new result only comes from a beat in work, and frees the input side
  `PIDAW_ASSERT_SAME(a_result_source, rst, $rose(out_valid), $past(in_stall) && !in_stall)

endmodule

bind pid_controller_antiwindup pidaw_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .drive     (drive),
  .clamped   (clamped)
);

`default_nettype wire
